FILE: design/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
package bba_pkg;

    localparam int NUM_BLOCKS_DEF = 1024;
    localparam int HEADER_BYTES   = 4;
    localparam int BPB_W          = 13;
    localparam int RSV_W          = 11;
    localparam int REQ_W          = 24;
    localparam int BLK_W          = 10;
    localparam int GRANT_W        = 23;
    localparam int CNT_W          = 11;
    localparam int NEED_W         = 25;

    localparam logic CFG_BPB = 1'b0;
    localparam logic CFG_RSV = 1'b1;

    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [REQ_W-1:0] request_bytes;
        logic [BLK_W-1:0] release_block;
    } t_req;

    typedef struct packed {
        logic               status;
        logic [BLK_W-1:0]   start_block;
        logic [GRANT_W-1:0] granted_bytes;
        logic [CNT_W-1:0]   released_blocks;
        logic [CNT_W-1:0]   free_blocks;
    } t_rsp;

    typedef struct packed {
        logic cfg_init;
        logic start_alloc;
        logic start_release;
        logic div_step;
        logic scan_step;
        logic mark_step;
        logic rel_step;
        logic finish;
        logic rel_load;
    } t_cmd;

    typedef struct packed {
        logic init_done;
        logic div_done;
        logic fast_fail;
        logic scan_found;
        logic scan_end;
        logic mark_done;
        logic rel_done;
    } t_sts;

endpackage

FILE: design/bba_ram.sv
// Generic single-port-write RAM with registered read.
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: design/bba_ctrl.sv
// Controller state machine of the bitmap block allocator.
module bba_ctrl
    import bba_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_mode,
    output logic o_req_stall,
    output logic o_rsp_valid,
    input  logic i_rsp_stall,
    input  logic i_cfg_init,
    output logic o_cfg_ready,
    output t_cmd o_cmd,
    input  t_sts i_sts
);
    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_DIV, S_SCAN, S_MARK, S_REL, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_rsp_valid, n_rsp_valid;
    logic   accept;

    assign accept      = (r_state == S_IDLE) && i_req_valid;
    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_cfg_ready = (r_state == S_IDLE) || (r_state == S_INIT);

    always_comb begin
        o_cmd               = '0;
        o_cmd.cfg_init      = i_cfg_init;
        o_cmd.start_alloc   = accept && (i_req_mode == MODE_ALLOC);
        o_cmd.start_release = accept && (i_req_mode == MODE_RELEASE);
        o_cmd.div_step      = (r_state == S_DIV);
        o_cmd.scan_step     = (r_state == S_SCAN);
        o_cmd.mark_step     = (r_state == S_MARK);
        o_cmd.rel_step      = (r_state == S_REL);
        o_cmd.rel_load      = o_cmd.start_release;
        o_cmd.finish        = 1'b0;
        n_state             = r_state;
        n_rsp_valid         = r_rsp_valid;
        case (r_state)
            S_INIT: begin
                if (i_sts.init_done && !i_cfg_init) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_cfg_init) begin
                    n_state = S_INIT;
                end else if (o_cmd.start_alloc) begin
                    n_state = S_DIV;
                end else if (o_cmd.start_release) begin
                    n_state = S_REL;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    if (i_sts.fast_fail) begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_OUT;
                        n_rsp_valid  = 1'b1;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (i_sts.scan_found) begin
                    n_state = S_MARK;
                end else if (i_sts.scan_end) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_OUT;
                    n_rsp_valid  = 1'b1;
                end
            end
            S_MARK: begin
                if (i_sts.mark_done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_OUT;
                    n_rsp_valid  = 1'b1;
                end
            end
            S_REL: begin
                if (i_sts.rel_done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_OUT;
                    n_rsp_valid  = 1'b1;
                end
            end
            S_OUT: begin
                if (!i_rsp_stall) begin
                    n_state     = S_IDLE;
                    n_rsp_valid = 1'b0;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (i_cfg_init && (r_state == S_INIT)) n_state = S_INIT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (r_state == S_OUT))
        else $error("response valid outside output state");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && i_rsp_stall) |=> o_rsp_valid)
        else $error("stalled response dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_DIV || r_state == S_REL))
        else $error("accepted request not started");
endmodule

FILE: design/bba_dp.sv
// Datapath of the bitmap block allocator: bitmap, divider, scan and release.
module bba_dp
    import bba_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  t_req             i_req,
    input  logic [BPB_W-1:0] i_bpb,
    input  logic [RSV_W-1:0] i_rsv,
    output t_rsp             o_rsp
);
    localparam int AW  = $clog2(NUM_BLOCKS);
    localparam int PW  = AW + 1;
    localparam int QW  = REQ_W + 1;
    localparam logic [PW-1:0] NB = PW'(NUM_BLOCKS);

    logic [PW-1:0]         r_hint, r_free, r_init_ptr, r_rsv;
    logic [NEED_W-1:0]     r_failed;
    logic                  r_init_busy;

    // Divider state.
    logic [QW-1:0]    r_num, r_quo;
    logic [BPB_W-1:0] r_rem, r_div;
    logic [4:0]       r_dcnt;
    logic             r_div_done;

    // Scan and run state.
    logic [PW-1:0]  r_ptr, r_cnt, r_start, r_mptr, r_mend;
    logic [CNT_W-1:0] r_rel_cnt;
    logic [1:0]     r_rel_ph;
    logic           r_rd_ph;
    logic [AW-1:0]  r_rel_blk;
    t_rsp           r_rsp;

    logic [BPB_W-1:0] bpb_eff;
    logic [PW-1:0]    rsv_eff;
    logic [QW-1:0]    need_q;
    logic [BPB_W:0]   rem_sh;
    logic [CNT_W-1:0] rl_rdata;
    logic             rl_we;
    logic [AW-1:0]    rl_waddr, rl_raddr;
    logic [CNT_W-1:0] rl_wdata;
    logic [PW-1:0]    ptr_last, span;
    logic             map_we, map_wdata, map_rdata;
    logic [AW-1:0]    map_waddr, map_raddr;

    assign bpb_eff = (i_bpb == '0) ? BPB_W'(1) :
                     (i_bpb > BPB_W'(4096)) ? BPB_W'(4096) : i_bpb;
    assign rsv_eff = ({21'd0, i_rsv} > 32'(NUM_BLOCKS)) ? NB : PW'(i_rsv);

    assign rem_sh  = {r_rem, r_num[QW-1]};
    assign need_q  = r_quo + QW'(r_rem != '0);
    assign span    = NB - r_hint;

    bba_ram #(.WIDTH(CNT_W), .DEPTH(NUM_BLOCKS)) u_len (
        .i_clk  (i_clk),
        .i_we   (rl_we),
        .i_waddr(rl_waddr),
        .i_wdata(rl_wdata),
        .i_raddr(rl_raddr),
        .o_rdata(rl_rdata)
    );

    bba_ram #(.WIDTH(1), .DEPTH(NUM_BLOCKS)) u_map (
        .i_clk  (i_clk),
        .i_we   (map_we),
        .i_waddr(map_waddr),
        .i_wdata(map_wdata),
        .i_raddr(map_raddr),
        .o_rdata(map_rdata)
    );

    assign rl_raddr = i_req.release_block[AW-1:0];
    assign rl_we    = r_init_busy || (i_cmd.mark_step && r_mptr == r_start) ||
                      (i_cmd.rel_step && r_rel_ph == 2'd1);
    assign rl_waddr = r_init_busy ? r_init_ptr[AW-1:0] :
                      i_cmd.mark_step ? r_start[AW-1:0] : r_rel_blk;
    assign rl_wdata = i_cmd.mark_step ? CNT_W'(r_cnt) : '0;
    assign ptr_last = r_ptr;

    assign map_we    = r_init_busy || i_cmd.mark_step ||
                       (i_cmd.rel_step && r_rel_ph == 2'd2 && r_rd_ph && r_mptr < r_mend);
    assign map_waddr = r_init_busy ? r_init_ptr[AW-1:0] : r_mptr[AW-1:0];
    assign map_wdata = r_init_busy ? (r_init_ptr < r_rsv) : i_cmd.mark_step;
    assign map_raddr = (r_rel_ph != 2'd0) ? r_mptr[AW-1:0] : r_ptr[AW-1:0];

    always_comb begin
        o_sts            = '0;
        o_sts.init_done  = !r_init_busy;
        o_sts.div_done   = r_div_done;
        o_sts.fast_fail  = (r_failed != '0) && (need_q >= r_failed);
        o_sts.scan_found = r_rd_ph && (r_ptr < NB) && !map_rdata &&
                           ({{(QW-PW){1'b0}}, r_cnt} + QW'(1) == r_quo);
        o_sts.scan_end   = (r_ptr >= NB) || ({{(QW-PW){1'b0}}, span} < r_quo);
        o_sts.mark_done  = (r_mptr + PW'(1) == r_mend);
        o_sts.rel_done   = (r_rel_ph == 2'd2) && (r_mptr >= r_mend);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_busy <= 1'b1;
            r_init_ptr  <= '0;
            r_rsv       <= '0;
            r_hint      <= '0;
            r_free      <= NB;
            r_failed    <= '0;
            r_div_done  <= 1'b0;
            r_rel_ph    <= '0;
            r_rd_ph     <= 1'b0;
        end else if (i_cmd.cfg_init) begin
            r_init_busy <= 1'b1;
            r_init_ptr  <= '0;
            r_rsv       <= rsv_eff;
            r_hint      <= rsv_eff;
            r_free      <= NB - rsv_eff;
            r_failed    <= '0;
        end else if (r_init_busy) begin
            r_init_ptr <= r_init_ptr + PW'(1);
            if (r_init_ptr == NB - PW'(1)) r_init_busy <= 1'b0;
        end else begin
            if (i_cmd.start_alloc) begin
                r_num      <= QW'(i_req.request_bytes) + QW'(HEADER_BYTES);
                r_rem      <= '0;
                r_div      <= bpb_eff;
                r_dcnt     <= 5'(QW);
                r_div_done <= 1'b0;
                r_quo      <= '0;
                r_rsp      <= '0;
                r_rd_ph    <= 1'b0;
            end
            if (i_cmd.div_step && !r_div_done) begin
                // One restoring step per cycle.
                if (rem_sh >= {1'b0, r_div}) begin
                    r_rem <= BPB_W'(rem_sh - {1'b0, r_div});
                    r_quo <= {r_quo[QW-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[BPB_W-1:0];
                    r_quo <= {r_quo[QW-2:0], 1'b0};
                end
                r_num  <= {r_num[QW-2:0], 1'b0};
                r_dcnt <= r_dcnt - 5'd1;
                if (r_dcnt == 5'd1) r_div_done <= 1'b1;
            end
            if (i_cmd.div_step && r_div_done) begin
                r_quo   <= need_q;
                r_ptr   <= r_hint;
                r_cnt   <= '0;
                r_rd_ph <= 1'b0;
                if (o_sts.fast_fail) begin
                    r_rsp.status <= 1'b1;
                    r_div_done   <= 1'b0;
                end
            end
            if (i_cmd.scan_step) begin
                if (o_sts.scan_found) begin
                    r_start <= ptr_last + PW'(1) - PW'(r_quo);
                    r_mptr  <= ptr_last + PW'(1) - PW'(r_quo);
                    r_mend  <= ptr_last + PW'(1);
                    r_cnt   <= PW'(r_quo);
                    r_rd_ph <= 1'b0;
                end else if (o_sts.scan_end) begin
                    r_rsp.status <= 1'b1;
                    r_failed     <= NEED_W'(r_quo);
                    r_div_done   <= 1'b0;
                    r_rd_ph      <= 1'b0;
                end else if (!r_rd_ph) begin
                    r_rd_ph <= 1'b1;
                end else begin
                    r_cnt   <= map_rdata ? '0 : r_cnt + PW'(1);
                    r_ptr   <= r_ptr + PW'(1);
                    r_rd_ph <= 1'b0;
                end
            end
            if (i_cmd.mark_step) begin
                r_mptr <= r_mptr + PW'(1);
                if (o_sts.mark_done) begin
                    r_free       <= r_free - r_cnt;
                    if (r_start == r_hint) r_hint <= r_hint + r_cnt;
                    r_failed     <= '0;
                    r_div_done   <= 1'b0;
                    r_rsp.start_block   <= BLK_W'(r_start);
                    r_rsp.granted_bytes <= GRANT_W'(r_cnt) * GRANT_W'(r_div);
                end
            end
            if (i_cmd.start_release) begin
                r_rsp     <= '0;
                r_failed  <= '0;
                r_rel_blk <= i_req.release_block[AW-1:0];
                r_rel_ph  <= 2'd1;
                r_rel_cnt <= '0;
            end
            if (i_cmd.rel_step) begin
                case (r_rel_ph)
                    2'd1: begin
                        r_mptr   <= PW'(r_rel_blk);
                        r_mend   <= ({1'b0, r_rel_blk} + PW'(rl_rdata) > NB ||
                                     {1'b0, r_rel_blk} + PW'(rl_rdata) <
                                     {1'b0, r_rel_blk}) ? NB :
                                    {1'b0, r_rel_blk} + PW'(rl_rdata);
                        r_rel_ph <= 2'd2;
                        r_rd_ph  <= 1'b0;
                    end
                    2'd2: begin
                        if (r_mptr < r_mend) begin
                            if (!r_rd_ph) begin
                                r_rd_ph <= 1'b1;
                            end else begin
                                if (map_rdata) begin
                                    r_rel_cnt <= r_rel_cnt + CNT_W'(1);
                                end
                                r_mptr  <= r_mptr + PW'(1);
                                r_rd_ph <= 1'b0;
                            end
                        end else begin
                            r_rel_ph <= 2'd0;
                            r_free   <= r_free + PW'(r_rel_cnt);
                            r_rsp.released_blocks <= r_rel_cnt;
                            if (r_rel_cnt != '0 && PW'(r_rel_blk) < r_hint) begin
                                r_hint <= PW'(r_rel_blk);
                            end
                        end
                    end
                    default: r_rel_ph <= 2'd0;
                endcase
            end
        end
    end

    always_comb begin
        o_rsp             = r_rsp;
        o_rsp.free_blocks = CNT_W'(r_free);
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free <= NB))
        else $error("free count above pool size");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mark_step |-> (r_mptr < r_mend))
        else $error("mark pointer past run end");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_init_busy) |-> (r_hint <= NB))
        else $error("hint beyond pool");
endmodule

FILE: design/bitmap_block_allocator_top.sv
// Top level of the bitmap block allocator.
//
// One request at a time. An allocate runs the serial ceiling divide, then
// scans the bitmap from the free hint and marks each block of the run it
// finds; a release reads the stored run length and clears each block of the
// run. After reset, and after each write of reserved_blocks, a clearing
// pass over all NUM_BLOCKS entries sets up the bitmap and clears the run-length
// table before requests are taken.
module bitmap_block_allocator_top
    import bba_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_stall,
    input  t_req             i_req,
    output logic             o_rsp_valid,
    input  logic             i_rsp_stall,
    output t_rsp             o_rsp,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [RSV_W+1:0] i_cfg_data
);
    logic [BPB_W-1:0] r_bpb;
    logic [RSV_W-1:0] r_rsv;
    logic             cfg_we, cfg_init;
    t_cmd             cmd;
    t_sts             sts;

    assign cfg_we   = i_cfg_valid && o_cfg_ready;
    assign cfg_init = cfg_we && (i_cfg_index == CFG_RSV);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpb <= BPB_W'(16);
            r_rsv <= '0;
        end else if (cfg_we) begin
            if (i_cfg_index == CFG_BPB) r_bpb <= i_cfg_data[BPB_W-1:0];
            else                        r_rsv <= i_cfg_data[RSV_W-1:0];
        end
    end

    bba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .i_req_mode (i_req.mode),
        .o_req_stall(o_req_stall),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_stall(i_rsp_stall),
        .i_cfg_init (cfg_init),
        .o_cfg_ready(o_cfg_ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    bba_dp #(.NUM_BLOCKS(NUM_BLOCKS)) u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd),
        .o_sts  (sts),
        .i_req  (i_req),
        .i_bpb  (r_bpb),
        .i_rsv  (cfg_init ? i_cfg_data[RSV_W-1:0] : r_rsv),
        .o_rsp  (o_rsp)
    );
endmodule

FILE: verif/bba_checker.sv
// Request/response checker for the bitmap block allocator: predicts and compares results.
`timescale 1ns / 1ps

module bba_checker
    import bba_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic             i_req_stall,
    input  t_req             i_req,
    input  logic             i_rsp_valid,
    input  logic             i_rsp_stall,
    input  t_rsp             i_rsp,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [RSV_W+1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);

    localparam int POOL = NUM_BLOCKS_DEF;

    bit          block_used [POOL];
    int unsigned block_run  [POOL];
    int unsigned free_hint;
    int unsigned failed_need;
    int unsigned free_total;
    int unsigned block_bytes;
    int unsigned reserved;
    t_rsp        expected_rsps [$];

    function automatic void init_pool();
        int unsigned r;
        r = (reserved > POOL) ? POOL : reserved;
        for (int i = 0; i < POOL; i++) begin
            block_used[i] = (i < r);
            block_run[i]  = 0;
        end
        free_hint   = r;
        failed_need = 0;
        free_total  = POOL - r;
    endfunction

    function automatic t_rsp predict_allocation(t_req r);
        t_rsp        p;
        int unsigned bpb, total, need, run, start, rel, stop, freed;
        bit          found;
        p     = '0;
        found = 0;
        start = 0;
        freed = 0;
        if (r.mode == MODE_ALLOC) begin
            bpb   = (block_bytes == 0) ? 1 : (block_bytes > 4096 ? 4096 : block_bytes);
            total = r.request_bytes + HEADER_BYTES;
            need  = total / bpb + ((total % bpb) != 0 ? 1 : 0);
            if (failed_need != 0 && need >= failed_need) begin
                p.status = 1'b1;
            end else begin
                run = 0;
                if (need <= POOL) begin
                    for (int unsigned i = free_hint; i < POOL; i++) begin
                        if (block_used[i]) begin
                            run = 0;
                        end else begin
                            run++;
                            if (run == need) begin
                                start = i + 1 - need;
                                found = 1;
                                break;
                            end
                        end
                    end
                end
                if (!found) begin
                    failed_need = need & 32'h1FF_FFFF;
                    p.status    = 1'b1;
                end else begin
                    for (int unsigned i = start; i < start + need; i++) block_used[i] = 1;
                    block_run[start] = need & 32'h7FF;
                    free_total -= need;
                    if (start == free_hint) free_hint += need;
                    failed_need     = 0;
                    p.start_block   = start[BLK_W-1:0];
                    p.granted_bytes = GRANT_W'(need * bpb);
                end
            end
        end else begin
            failed_need = 0;
            rel  = r.release_block;
            stop = rel + block_run[rel];
            if (stop > POOL) stop = POOL;
            for (int unsigned i = rel; i < stop; i++) begin
                if (block_used[i]) begin
                    block_used[i] = 0;
                    freed++;
                end
            end
            block_run[rel] = 0;
            free_total += freed;
            if (freed != 0 && rel < free_hint) free_hint = rel;
            p.released_blocks = CNT_W'(freed);
        end
        p.free_blocks = CNT_W'(free_total);
        return p;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, field, got, want);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;
    assign o_pending = expected_rsps.size();

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            block_bytes = 16;
            reserved    = 0;
            init_pool();
            expected_rsps.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_BPB) begin
                    block_bytes = i_cfg_data;
                end else begin
                    reserved = i_cfg_data[RSV_W-1:0];
                    init_pool();
                end
            end
            if (i_rsp_valid && !i_rsp_stall) begin
                if (expected_rsps.size() == 0) begin
                    $display("%0t: response with no request outstanding", $time);
                    o_fail_count++;
                end else begin
                    want = expected_rsps.pop_front();
                    if (i_rsp.status !== want.status)
                        report_mismatch("status", i_rsp.status, want.status);
                    if (i_rsp.start_block !== want.start_block)
                        report_mismatch("start_block", i_rsp.start_block, want.start_block);
                    if (i_rsp.granted_bytes !== want.granted_bytes)
                        report_mismatch("granted_bytes", i_rsp.granted_bytes,
                                        want.granted_bytes);
                    if (i_rsp.released_blocks !== want.released_blocks)
                        report_mismatch("released_blocks", i_rsp.released_blocks,
                                        want.released_blocks);
                    if (i_rsp.free_blocks !== want.free_blocks)
                        report_mismatch("free_blocks", i_rsp.free_blocks, want.free_blocks);
                end
            end
            if (i_req_valid && !i_req_stall) expected_rsps.push_back(predict_allocation(i_req));
        end
    end

endmodule

FILE: verif/bitmap_block_allocator_top_tb.sv
// Testbench top for the bitmap block allocator: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps

module bitmap_block_allocator_top_tb;
    import bba_pkg::*;

    localparam int POOL      = NUM_BLOCKS_DEF;
    localparam int STALL_GAP = 10;
    localparam int HOLD_LEN  = 400;
    localparam int WD_LIMIT  = 20000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_req_valid = 1'b0;
    logic             o_req_stall;
    t_req             i_req = '0;
    logic             o_rsp_valid;
    logic             i_rsp_stall = 1'b1;
    t_rsp             o_rsp;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic             i_cfg_index = CFG_BPB;
    logic [RSV_W+1:0] i_cfg_data = '0;

    int fail_count, pending;
    int n_sent, n_rcvd, n_alloc, n_release, n_settings, idle_cycles;
    bit idle_on = 1'b1;
    bit hold_req = 1'b0;
    bit granted_start [POOL];
    int known_starts [$];

    always #5 i_clk = ~i_clk;

    bitmap_block_allocator_top i_dut (.*);

    bba_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(i_req_valid), .i_req_stall(o_req_stall), .i_req(i_req),
        .i_rsp_valid(o_rsp_valid), .i_rsp_stall(i_rsp_stall), .i_rsp(o_rsp),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // track accepted requests and granted starts; watchdog on silence
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_req_valid && !o_req_stall) n_sent++;
            if (o_rsp_valid && !i_rsp_stall) begin
                n_rcvd++;
                if (!o_rsp.status && o_rsp.granted_bytes != 0
                        && !granted_start[o_rsp.start_block]) begin
                    granted_start[o_rsp.start_block] = 1;
                    known_starts.push_back(o_rsp.start_block);
                end
            end
            if ((i_req_valid && !o_req_stall) || (o_rsp_valid && !i_rsp_stall)
                    || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WD_LIMIT) begin
                $display("watchdog expired after %0d idle cycles", idle_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // response side
    initial begin
        int w;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                i_rsp_stall <= 1'b1;
                repeat (HOLD_LEN) @(negedge i_clk);
            end
            w = idle_on ? $urandom_range(0, STALL_GAP) : 0;
            if (w > 0) begin
                i_rsp_stall <= 1'b1;
                repeat (w) @(negedge i_clk);
            end
            i_rsp_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_rsp_valid && !i_rsp_stall));
        end
    end

    task automatic send_request(logic mode, logic [REQ_W-1:0] bytes, logic [BLK_W-1:0] blk);
        int g;
        t_req r;
        r.mode          = mode;
        r.request_bytes = bytes;
        r.release_block = blk;
        g = idle_on ? $urandom_range(0, STALL_GAP) : 0;
        if (g > 0) begin
            i_req_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_req       <= r;
        i_req_valid <= 1'b1;
        do @(posedge i_clk); while (!(i_req_valid && !o_req_stall));
        @(negedge i_clk);
        if (mode == MODE_ALLOC) n_alloc++;
        else n_release++;
    endtask

    task automatic drain();
        i_req_valid <= 1'b0;
        @(negedge i_clk);
        while (n_rcvd != n_sent) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [RSV_W+1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_RSV) begin
            foreach (granted_start[i]) granted_start[i] = 0;
            known_starts.delete();
        end
    endtask

    task automatic set_pool(int bpb, int rsv);
        drain();
        write_reg(CFG_BPB, bpb);
        write_reg(CFG_RSV, rsv);
        n_settings++;
    endtask

    task automatic random_phase(int count, int bpb, bit pressure);
        int unsigned span;
        span = (bpb == 0 ? 1 : (bpb > 4096 ? 4096 : bpb)) * 16;
        for (int k = 0; k < count; k++) begin
            if (pressure && k == count / 3) hold_req = 1;
            if (pressure && k == 2 * count / 3) drain();
            if (known_starts.size() != 0 && $urandom_range(0, 9) < 4)
                send_request(MODE_RELEASE, $urandom,
                             known_starts[$urandom_range(0, known_starts.size() - 1)]);
            else if ($urandom_range(0, 19) == 0)
                send_request(MODE_ALLOC, $urandom, $urandom);
            else
                send_request(MODE_ALLOC, $urandom_range(0, span), $urandom);
        end
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        set_pool(16, 0);
        send_request(MODE_ALLOC, 0, 10'h3FF);
        send_request(MODE_ALLOC, 12, 0);
        send_request(MODE_ALLOC, 13, 0);
        send_request(MODE_ALLOC, 24'hFFFFFF, 0);
        send_request(MODE_ALLOC, 24'hFFFFFF, 0);
        send_request(MODE_ALLOC, 20000, 0);
        send_request(MODE_ALLOC, 100, 0);
        send_request(MODE_RELEASE, 0, 0);
        send_request(MODE_RELEASE, 24'hFFFFFF, 0);
        send_request(MODE_RELEASE, 0, 2);
        send_request(MODE_ALLOC, 0, 0);
        send_request(MODE_ALLOC, 16 * 1024 - 4, 0);
        send_request(MODE_ALLOC, 16 * 1000, 0);
        send_request(MODE_RELEASE, 0, 1);
        send_request(MODE_ALLOC, 16 * 1000, 0);
        random_phase(120, 16, 1);

        set_pool(1, 1024);
        send_request(MODE_ALLOC, 0, 0);
        send_request(MODE_ALLOC, 0, 0);
        send_request(MODE_ALLOC, 24'hFFFFFF, 0);
        set_pool(4096, 0);
        random_phase(120, 4096, 0);
        set_pool(0, 1023);
        send_request(MODE_ALLOC, 0, 0);
        set_pool(5, 1023);
        send_request(MODE_ALLOC, 0, 0);
        send_request(MODE_RELEASE, 0, 10'h3FF);
        send_request(MODE_ALLOC, 1, 0);
        set_pool(8191, 2047);
        send_request(MODE_ALLOC, 0, 0);
        set_pool(1, 0);
        random_phase(130, 1, 0);
        set_pool(7, 300);
        random_phase(120, 7, 1);
        idle_on = 0;
        set_pool(3, 0);
        random_phase(130, 3, 0);
        idle_on = 1;
        set_pool(64, 17);
        random_phase(120, 64, 0);
        drain();
        repeat (3000) @(negedge i_clk);

        $display("Sent %0d allocates and %0d releases over %0d pool settings,",
                 n_alloc, n_release, n_settings);
        $display("including full, saturated and backpressured pools.");
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d responses missing", fail_count, pending);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
